[hw/rtl/rrc_pkg.sv]
// Shared types, constants and decode helpers for the request replay cache.
package rrc_pkg;

	// Protocol constants
	localparam logic [10:0] LEN_MASK         = 11'h7FF;
	localparam logic [15:0] META_TABLE       = 16'h8420;
	localparam int          WRITE_BIT        = 15;
	localparam int          META_SHIFT       = 13;
	localparam int          HEADER_BYTES     = 16;
	localparam int          MAX_PACKET_BYTES = 2048;

	localparam int          ANS_LIMIT_I = (MAX_PACKET_BYTES - 1 < 2047) ?
	                                      (MAX_PACKET_BYTES - 1) : 2047;
	localparam logic [11:0] ANS_LIMIT   = 12'(ANS_LIMIT_I);
	localparam logic [10:0] HDR_LEN     = 11'(HEADER_BYTES);
	localparam logic [10:0] ERR_DATA_LEN = 11'd2;

	// Stream widths
	localparam int IN_TDATA_W  = 184;
	localparam int OUT_TDATA_W = 48;

	// Item kinds on the input tuser
	localparam logic KIND_LOOKUP     = 1'b0;
	localparam logic KIND_COMPLETION = 1'b1;

	// One input word
	typedef struct packed {
		logic        kind;
		logic [31:0] src_ip;
		logic [15:0] src_port;
		logic [15:0] request_id;
		logic [15:0] len_cmd;
		logic [15:0] reg_address;
		logic [31:0] reg_offset;
		logic [10:0] packet_len;
		logic [31:0] result_code;
		logic [10:0] read_len;
	} in_item_t;

	// One result word
	typedef struct packed {
		logic        hit;
		logic [2:0]  entry;
		logic        is_write;
		logic [10:0] data_len;
		logic [3:0]  meta_len;
		logic [15:0] answer_len_cmd;
		logic [10:0] answer_len;
	} result_t;

	// Key stored per cache entry
	typedef struct packed {
		logic [31:0] ip;
		logic [15:0] port;
		logic [15:0] request_id;
		logic [15:0] len_cmd;
		logic [15:0] address;
		logic [31:0] offset;
		logic [10:0] request_len;
	} key_t;

	localparam int KEY_W = $bits(key_t);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} st_t;

	// Metadata size in bytes from the two-bit size code
	function automatic logic [3:0] meta_of(input logic [15:0] lc);
		logic [1:0]  code;
		logic [15:0] sh;
		code = lc[META_SHIFT +: 2];
		sh   = META_TABLE >> {code, 2'b00};
		return sh[3:0];
	endfunction

endpackage

[hw/rtl/rrc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rrc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/rrc_engine.sv]
// Lookup/allocate and completion engine: key and answer RAMs, scan FSM, result forming.
module rrc_engine
	import rrc_pkg::*;
#(
	parameter int CACHE_ENTRIES = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	input  logic      out_free,
	output logic      res_valid,
	output result_t   res
);

	localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(CACHE_ENTRIES - 1);

	st_t state_q, state_d;

	in_item_t req_q;
	logic [IW-1:0] rd_idx_q;
	logic          rd_kv_q, rd_av_q;
	logic [CACHE_ENTRIES-1:0] key_valid_q, ans_valid_q;
	logic          hit_q;
	logic [IW-1:0] hit_idx_q;
	logic [10:0]   hit_alen_q;
	logic [IW-1:0] victim_q, pend_idx_q;
	logic [15:0]   pend_lc_q;

	logic          accept, rd_en, match, last, finish;
	logic [IW-1:0] rd_addr;
	key_t          req_key, key_rdata, key_rd;
	logic [10:0]   ans_rdata, ans_rd;
	logic          key_we, ans_we;

	// completion math
	logic          err, c_wr;
	logic [10:0]   adlen;
	logic [11:0]   total_w;
	logic [10:0]   total;
	// lookup math
	logic          l_wr;
	logic [10:0]   l_dlen;
	logic [IW-1:0] ent_idx;
	logic [IW+2:0] ent_ext;

	assign accept = in_valid && in_ready;
	assign finish = (state_q == ST_DONE) && out_free;

	// key of the request held for this lookup
	always_comb begin
		req_key.ip          = req_q.src_ip;
		req_key.port        = req_q.src_port;
		req_key.request_id  = req_q.request_id;
		req_key.len_cmd     = req_q.len_cmd;
		req_key.address     = req_q.reg_address;
		req_key.offset      = req_q.reg_offset;
		req_key.request_len = req_q.packet_len;
	end

	// entries never written read as zero
	assign key_rd = rd_kv_q ? key_rdata : '0;
	assign ans_rd = rd_av_q ? ans_rdata : '0;
	assign match  = (key_rd == req_key);
	assign last   = (rd_idx_q == LAST_IDX);

	// scan read address: entry 0 at accept, then one entry per cycle
	assign rd_en   = (accept && (in_item.kind == KIND_LOOKUP)) ||
	                 ((state_q == ST_SCAN) && !match && !last);
	assign rd_addr = accept ? '0 : (rd_idx_q + 1'b1);

	assign key_we = finish && (req_q.kind == KIND_LOOKUP) && !hit_q;
	assign ans_we = finish && (req_q.kind == KIND_COMPLETION);

	rrc_ram #(.WIDTH(KEY_W), .DEPTH(CACHE_ENTRIES)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (victim_q),
		.wdata (req_key),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (key_rdata)
	);

	rrc_ram #(.WIDTH(11), .DEPTH(CACHE_ENTRIES)) u_ans_ram (
		.clk   (clk),
		.we    (ans_we),
		.waddr (pend_idx_q),
		.wdata (total),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (ans_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (in_item.kind == KIND_COMPLETION) ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (match || last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// completion answer
	always_comb begin
		c_wr = pend_lc_q[WRITE_BIT];
		err  = (req_q.result_code != '0);
		if (err) begin
			adlen = ERR_DATA_LEN;
		end else if (!c_wr) begin
			adlen = req_q.read_len;
		end else begin
			adlen = '0;
		end
		total_w = {1'b0, adlen} + {1'b0, HDR_LEN};
		total   = (total_w > ANS_LIMIT) ? ANS_LIMIT[10:0] : total_w[10:0];
	end

	// lookup decode
	always_comb begin
		l_wr = req_q.len_cmd[WRITE_BIT];
		if (l_wr) begin
			l_dlen = (req_q.packet_len >= HDR_LEN) ? (req_q.packet_len - HDR_LEN) : '0;
		end else begin
			l_dlen = req_q.len_cmd[10:0] & LEN_MASK;
		end
	end

	assign ent_ext = {3'b000, ent_idx};

	// outputs
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		res_valid = finish;
		ent_idx   = pend_idx_q;
		res       = '0;
		if (req_q.kind == KIND_COMPLETION) begin
			ent_idx            = pend_idx_q;
			res.hit            = 1'b0;
			res.is_write       = c_wr;
			res.data_len       = adlen;
			res.meta_len       = meta_of(pend_lc_q);
			res.answer_len_cmd = err ? (pend_lc_q | {5'b00000, LEN_MASK}) : pend_lc_q;
			res.answer_len     = total;
		end else begin
			ent_idx            = hit_q ? hit_idx_q : victim_q;
			res.hit            = hit_q;
			res.is_write       = l_wr;
			res.data_len       = l_dlen;
			res.meta_len       = meta_of(req_q.len_cmd);
			res.answer_len_cmd = '0;
			res.answer_len     = hit_q ? hit_alen_q : '0;
		end
		res.entry = ent_ext[2:0];
	end

	// state register and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			key_valid_q <= '0;
			ans_valid_q <= '0;
			victim_q    <= '0;
			pend_idx_q  <= '0;
			pend_lc_q   <= '0;
			hit_q       <= 1'b0;
			rd_kv_q     <= 1'b0;
			rd_av_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				hit_q <= 1'b0;
			end else if ((state_q == ST_SCAN) && match) begin
				hit_q <= 1'b1;
			end
			if (rd_en) begin
				rd_kv_q <= key_valid_q[rd_addr];
				rd_av_q <= ans_valid_q[rd_addr];
			end
			// allocate on miss
			if (key_we) begin
				key_valid_q[victim_q] <= 1'b1;
				victim_q   <= (victim_q == LAST_IDX) ? '0 : (victim_q + 1'b1);
				pend_idx_q <= victim_q;
				pend_lc_q  <= req_q.len_cmd;
			end
			if (ans_we) begin
				ans_valid_q[pend_idx_q] <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_item;
		end
		if (rd_en) begin
			rd_idx_q <= rd_addr;
		end
		if ((state_q == ST_SCAN) && match) begin
			hit_idx_q  <= rd_idx_q;
			hit_alen_q <= ans_rd;
		end
	end

endmodule

[hw/rtl/request_replay_cache.sv]
// Top level of the request replay cache: stream unpacking, engine and output register.
//
// Slave stream (s_*) carries request lookups (tuser = 0) and completions of the
// last allocated request (tuser = 1). Master stream (m_*) returns one word per
// input word; tuser marks a cache hit whose stored answer may be replayed.
// A lookup reads the key RAM one entry per cycle from entry 0 until the first
// match, or through every entry on a miss. The result word then passes the
// DONE state and the output register to m_tvalid, and the engine takes the
// next input word once it is back in IDLE. The single read port of the key RAM
// sets the pace of the scan. A completion goes straight from accept to the DONE
// state and then through the output register.
// One word is in work at a time: s_tready is high only while the engine is idle.
// Results sit in an output register; the engine hands over a new result when
// that register is empty or being read, and then takes the next input word
// while the result still waits. A stalled m_tready holds the result and, once
// the following word is done, holds the engine as well.
// Reset clears the entry valid bits (all entries read as zero, answer length 0),
// the round-robin victim pointer and the pending entry; no clearing pass is run.
module request_replay_cache
	import rrc_pkg::*;
#(
	parameter int CACHE_ENTRIES = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// src_ip, src_port, request_id, len_cmd, reg_address, reg_offset,
	// packet_len, result_code, read_len (low bit up), zero padded
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// kind
	input  logic                   s_tuser,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// entry, is_write, data_len, meta_len, answer_len_cmd, answer_len
	// (low bit up), zero padded
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// hit
	output logic                   m_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready
);

	in_item_t item;
	result_t  res;
	logic     res_valid, out_free;
	logic     m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic     m_tuser_q;

	// unpack input word
	always_comb begin
		item.kind        = s_tuser;
		item.src_ip      = s_tdata[31:0];
		item.src_port    = s_tdata[47:32];
		item.request_id  = s_tdata[63:48];
		item.len_cmd     = s_tdata[79:64];
		item.reg_address = s_tdata[95:80];
		item.reg_offset  = s_tdata[127:96];
		item.packet_len  = s_tdata[138:128];
		item.result_code = s_tdata[170:139];
		item.read_len    = s_tdata[181:171];
	end

	assign out_free = !m_tvalid_q || m_tready;

	rrc_engine #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (item),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= res_valid;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			m_tuser_q <= res.hit;
			m_tdata_q <= {2'b00, res.answer_len, res.answer_len_cmd, res.meta_len,
			              res.data_len, res.is_write, res.entry};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

[hw/rtl/rrc_checker.sv]
// Port-level checks for the request replay cache, bound to the top level.
module rrc_checker
	import rrc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   m_tuser,
	input  logic                   m_tvalid,
	input  logic                   m_tready
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// one word in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while previous word still in work");

	// a hit never carries an answer command word
	a_hit_no_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata[34:19] == 16'h0000))
		else $error("hit result carries an answer command word");

	// metadata length is 0, 2, 4 or 8
	a_meta_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[18:15] == 4'd0) || (m_tdata[18:15] == 4'd2) ||
		             (m_tdata[18:15] == 4'd4) || (m_tdata[18:15] == 4'd8))
		else $error("metadata length outside 0, 2, 4, 8");

endmodule

bind request_replay_cache rrc_checker u_rrc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);
